### sv/heat_diffusion_stencil_2d_macros.svh
// ----------------------------------------------------------------------------
// heat diffusion stencil assertion macros
// shared clocked assertion forms
// ----------------------------------------------------------------------------
`ifndef HEAT_DIFFUSION_STENCIL_2D_MACROS_SVH
`define HEAT_DIFFUSION_STENCIL_2D_MACROS_SVH

// implication checked on every edge outside reset
`define HDS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/hds_pkg.sv
// ----------------------------------------------------------------------------
// hds_pkg
// shared types and constants of the heat diffusion stencil
// ----------------------------------------------------------------------------
package hds_pkg;

	localparam int MAX_DIM_DEF    = 128;
	localparam int VALUE_BITS_DEF = 32;
	localparam int COEF_BITS      = 24;
	localparam int DIM_BITS       = 8;
	localparam int IDX_BITS       = 7;
	localparam int STEP_BITS      = 16;

	typedef enum logic [1:0] {
		ACT_FILL    = 2'd0,
		ACT_WRITE   = 2'd1,
		ACT_ADVANCE = 2'd2,
		ACT_READ    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_ROWS   = 2'd0,
		REG_COLS   = 2'd1,
		REG_COEF_X = 2'd2,
		REG_COEF_Y = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_CELL,
		ST_STEP,
		ST_EDGE,
		ST_DONE
	} back_state_t;

	// one queued request
	typedef struct packed {
		action_t               action;
		logic [IDX_BITS-1:0]   row;
		logic [IDX_BITS-1:0]   col;
		logic signed [31:0]    cell_value;
		logic [STEP_BITS-1:0]  step_count;
	} req_t;

endpackage

### sv/hds_front.sv
// ----------------------------------------------------------------------------
// hds_front
// request intake and two-entry queue toward the grid engine
// ----------------------------------------------------------------------------
module hds_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  hds_pkg::req_t  req,
	output logic           q_valid,
	output hds_pkg::req_t  q_req,
	input  logic           q_pop
);

	hds_pkg::req_t  mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           push;

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_req   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

### sv/hds_back.sv
// ----------------------------------------------------------------------------
// hds_back
// grid engine: ping-pong memories, fills, writes, stencil sweep, edge copy, reads
// ----------------------------------------------------------------------------
module hds_back #(
	parameter int MAX_DIM    = hds_pkg::MAX_DIM_DEF,
	parameter int VALUE_BITS = hds_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  hds_pkg::req_t                     q_req,
	output logic                              q_pop,
	input  logic [hds_pkg::DIM_BITS-1:0]      grid_rows,
	input  logic [hds_pkg::DIM_BITS-1:0]      grid_cols,
	input  logic [hds_pkg::COEF_BITS-1:0]     coef_x,
	input  logic [hds_pkg::COEF_BITS-1:0]     coef_y,
	output logic                              done,
	output logic signed [31:0]                result_value,
	output logic                              is_read,
	output logic                              saturated
);

	localparam int AW    = $clog2(MAX_DIM);
	localparam int CW    = 2 * AW;
	localparam int CELLS = 1 << CW;
	localparam int VB    = VALUE_BITS;
	localparam int LB    = VB + 3;
	localparam int PB    = LB + 13;
	localparam int SB    = PB + 1;
	localparam int DB    = VB + 3;
	localparam int DMW   = (AW + 1 > hds_pkg::DIM_BITS) ? AW + 1 : hds_pkg::DIM_BITS;

	logic signed [VB-1:0] mem_a [CELLS];
	logic signed [VB-1:0] mem_b [CELLS];

	hds_pkg::back_state_t state_q, state_d;

	logic [DMW-1:0] rows, cols;
	logic [DMW-1:0] r_q, c_q;
	logic [2:0]     ph_q;
	logic [hds_pkg::STEP_BITS-1:0] steps_q;
	logic           sel_q, sat_q, edge_q;
	hds_pkg::action_t act_q;
	logic [hds_pkg::IDX_BITS-1:0] rr_q, cc_q;
	logic signed [VB-1:0] val_q;

	// memory ports
	logic            ra_en, wa_en, rb_en, wb_en;
	logic [CW-1:0]   ra_addr, rb_addr, wa_addr, wb_addr;
	logic signed [VB-1:0] ra_q, rb_q, wa_data, wb_data;

	logic signed [VB-1:0] u_q, e_q, w_q, n_q, s_q;
	logic            in_rng;
	logic signed [VB-1:0] sat_in;
	logic signed [LB-1:0] lx_s1, ly_s1;
	logic signed [VB-1:0] u_s1;
	logic signed [PB-1:0] hx_s2, hy_s2, lox_s2, loy_s2;
	logic signed [VB-1:0] u_s2;
	logic signed [SB-1:0] hi, lo;
	logic signed [DB-1:0] dsum;
	logic signed [DB:0]   nv;
	logic signed [VB-1:0] nv_sat;
	logic            nv_ovf;
	logic signed [VB-1:0] rd_cur;
	logic signed [31:0] rd_sat;
	logic [3:0]      pv_q;
	logic            pv_in;
	logic [CW-1:0]   pa_s1, pa_s2, pa_s3;
	logic [CW-1:0]   ea_q;
	logic signed [VB-1:0] nv_s3;
	logic            rd_en, wr_cur, wr_nxt;
	logic [CW-1:0]   rd_addr, wr_addr;
	logic signed [VB-1:0] wr_data;
	logic            edge_rd;
	logic [CW-1:0]   eg_src;

	function automatic logic [DMW-1:0] eff(input logic [hds_pkg::DIM_BITS-1:0] v);
		logic [DMW-1:0] x;
		x = DMW'(v);
		if (x < DMW'(3)) return DMW'(3);
		if (x > DMW'(MAX_DIM)) return DMW'(MAX_DIM);
		return x;
	endfunction

	function automatic logic [CW-1:0] addr(input logic [DMW-1:0] r, input logic [DMW-1:0] c);
		return {r[AW-1:0], c[AW-1:0]};
	endfunction

	assign rows = eff(grid_rows);
	assign cols = eff(grid_cols);

	// saturate the 32-bit input to the value width
	always_comb begin
		if (VB >= 32) begin
			sat_in = VB'(q_req.cell_value);
		end else if (q_req.cell_value > 32'sd0 && (q_req.cell_value >>> (VB - 1)) != 0) begin
			sat_in = {1'b0, {(VB-1){1'b1}}};
		end else if (q_req.cell_value < 32'sd0 && (q_req.cell_value >>> (VB - 1)) != -32'sd1) begin
			sat_in = {1'b1, {(VB-1){1'b0}}};
		end else begin
			sat_in = VB'(q_req.cell_value);
		end
	end

	assign in_rng = (DMW'(q_req.row) < rows) && (DMW'(q_req.col) < cols);

	always_ff @(posedge clk) begin
		if (ra_en) ra_q <= mem_a[ra_addr];
		if (wa_en) mem_a[wa_addr] <= wa_data;
	end
	always_ff @(posedge clk) begin
		if (rb_en) rb_q <= mem_b[rb_addr];
		if (wb_en) mem_b[wb_addr] <= wb_data;
	end

	// read from the current grid, write the next one (or the current for fill/write)
	assign rd_cur = sel_q ? rb_q : ra_q;

	// edge copy uses the read port of the next grid
	always_comb begin
		ra_en   = (rd_en && !sel_q) || (edge_rd && sel_q);
		rb_en   = (rd_en && sel_q) || (edge_rd && !sel_q);
		ra_addr = edge_rd ? eg_src : rd_addr;
		rb_addr = edge_rd ? eg_src : rd_addr;
		wa_addr = wr_addr;
		wb_addr = wr_addr;
		wa_data = wr_data;
		wb_data = wr_data;
		wa_en   = (wr_cur && !sel_q) || (wr_nxt && sel_q);
		wb_en   = (wr_cur && sel_q) || (wr_nxt && !sel_q);
	end

	// arithmetic pipe
	always_ff @(posedge clk) begin
		lx_s1  <= LB'(e_q) + LB'(w_q) - (LB'(u_q) <<< 1);
		ly_s1  <= LB'(n_q) + LB'(s_q) - (LB'(u_q) <<< 1);
		u_s1   <= u_q;
		pa_s1  <= ea_q;
		hx_s2  <= PB'(lx_s1) * $signed({1'b0, coef_x[23:12]});
		hy_s2  <= PB'(ly_s1) * $signed({1'b0, coef_y[23:12]});
		lox_s2 <= PB'(lx_s1) * $signed({1'b0, coef_x[11:0]});
		loy_s2 <= PB'(ly_s1) * $signed({1'b0, coef_y[11:0]});
		u_s2   <= u_s1;
		pa_s2  <= pa_s1;
		nv_s3  <= nv_sat;
		pa_s3  <= pa_s2;
	end

	assign hi   = SB'(hx_s2) + SB'(hy_s2);
	assign lo   = SB'(lox_s2) + SB'(loy_s2) + (SB'(1) <<< 23);
	assign dsum = DB'((hi + (lo >>> 12)) >>> 12);
	assign nv   = (DB+1)'(u_s2) + (DB+1)'(dsum);
	always_comb begin
		nv_ovf = 1'b0;
		nv_sat = VB'(nv);
		if (nv > (DB+1)'($signed({1'b0, {(VB-1){1'b1}}}))) begin
			nv_ovf = 1'b1;
			nv_sat = {1'b0, {(VB-1){1'b1}}};
		end else if (nv < -((DB+1)'($signed({1'b0, {(VB-1){1'b1}}}))) - 1) begin
			nv_ovf = 1'b1;
			nv_sat = {1'b1, {(VB-1){1'b0}}};
		end
	end

	always_comb begin
		if (VB > 32 && rd_cur > VB'(32'sh7fffffff)) rd_sat = 32'sh7fffffff;
		else if (VB > 32 && rd_cur < -VB'(32'sh7fffffff) - 1) rd_sat = 32'sh80000000;
		else rd_sat = 32'(rd_cur);
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			hds_pkg::ST_IDLE: begin
				if (q_valid) begin
					case (q_req.action)
						hds_pkg::ACT_FILL:    state_d = hds_pkg::ST_FILL;
						hds_pkg::ACT_WRITE:   state_d = hds_pkg::ST_IDLE;
						hds_pkg::ACT_ADVANCE: state_d = (q_req.step_count == '0) ?
							hds_pkg::ST_DONE : hds_pkg::ST_STEP;
						default:              state_d = hds_pkg::ST_DONE;
					endcase
				end
			end
			hds_pkg::ST_FILL: begin
				if (r_q == rows - DMW'(1) && c_q == cols - DMW'(1)) state_d = hds_pkg::ST_IDLE;
			end
			hds_pkg::ST_STEP: begin
				if (edge_q && pv_q == '0) state_d = hds_pkg::ST_EDGE;
			end
			hds_pkg::ST_EDGE: begin
				if (ph_q == 3'd2 && r_q == rows - DMW'(1) && c_q == cols - DMW'(1)) begin
					state_d = (steps_q == 16'd1) ? hds_pkg::ST_DONE : hds_pkg::ST_STEP;
				end
			end
			hds_pkg::ST_DONE:  state_d = hds_pkg::ST_IDLE;
			default:           state_d = hds_pkg::ST_IDLE;
		endcase
	end

	// datapath control outputs
	always_comb begin
		q_pop   = (state_q == hds_pkg::ST_IDLE) && q_valid;
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_cur  = 1'b0;
		wr_nxt  = 1'b0;
		wr_addr = '0;
		wr_data = nv_s3;
		case (state_q)
			hds_pkg::ST_IDLE: begin
				rd_en   = q_valid && q_req.action == hds_pkg::ACT_READ;
				rd_addr = addr(DMW'(q_req.row), DMW'(q_req.col));
				wr_cur  = q_valid && q_req.action == hds_pkg::ACT_WRITE && in_rng;
				wr_addr = addr(DMW'(q_req.row), DMW'(q_req.col));
				wr_data = sat_in;
			end
			hds_pkg::ST_FILL: begin
				wr_cur  = 1'b1;
				wr_addr = addr(r_q, c_q);
				wr_data = val_q;
			end
			hds_pkg::ST_STEP: begin
				rd_en   = !edge_q;
				case (ph_q)
					3'd0: rd_addr = addr(r_q, c_q);
					3'd1: rd_addr = addr(r_q + DMW'(1), c_q);
					3'd2: rd_addr = addr(r_q - DMW'(1), c_q);
					3'd3: rd_addr = addr(r_q, c_q - DMW'(1));
					default: rd_addr = addr(r_q, c_q + DMW'(1));
				endcase
				wr_nxt  = pv_q[3];
				wr_addr = pa_s3;
			end
			hds_pkg::ST_EDGE: begin
				wr_nxt  = (ph_q == 3'd2);
				wr_addr = ea_q;
				wr_data = sel_q ? ra_q : rb_q;
			end
			default: ;
		endcase
	end

	// the edge pass reads the next grid, so swap the port roles there
	assign edge_rd = (state_q == hds_pkg::ST_EDGE) && ph_q != 3'd2;
	always_comb begin
		logic [DMW-1:0] sr, sc;
		sr = r_q;
		sc = c_q;
		if (c_q == '0) sc = DMW'(1);
		else if (c_q == cols - DMW'(1)) sc = cols - DMW'(2);
		if (r_q == '0) sr = DMW'(1);
		else if (r_q == rows - DMW'(1)) sr = rows - DMW'(2);
		eg_src = addr(sr, sc);
	end

	assign pv_in = (state_q == hds_pkg::ST_STEP) && !edge_q && ph_q == 3'd5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hds_pkg::ST_IDLE;
			sel_q   <= 1'b0;
			sat_q   <= 1'b0;
			done    <= 1'b0;
			is_read <= 1'b0;
			pv_q    <= '0;
			ph_q    <= '0;
			edge_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= (state_q == hds_pkg::ST_DONE);
			pv_q    <= {pv_q[2:0], pv_in};
			if (pv_q[2] && nv_ovf) sat_q <= 1'b1;
			case (state_q)
				hds_pkg::ST_IDLE: begin
					if (q_valid) begin
						act_q <= q_req.action;
						rr_q  <= q_req.row;
						cc_q  <= q_req.col;
						val_q <= sat_in;
						r_q   <= (q_req.action == hds_pkg::ACT_ADVANCE) ? DMW'(1) : '0;
						c_q   <= (q_req.action == hds_pkg::ACT_ADVANCE) ? DMW'(1) : '0;
						ph_q  <= '0;
						steps_q <= q_req.step_count;
						if (q_req.action == hds_pkg::ACT_ADVANCE) begin
							sat_q <= 1'b0;
							edge_q <= 1'b0;
						end
					end
				end
				hds_pkg::ST_FILL: begin
					if (c_q == cols - DMW'(1)) begin
						c_q <= '0;
						r_q <= r_q + DMW'(1);
					end else begin
						c_q <= c_q + DMW'(1);
					end
				end
				hds_pkg::ST_STEP: begin
					if (!edge_q) begin
						case (ph_q)
							3'd1: u_q <= rd_cur;
							3'd2: e_q <= rd_cur;
							3'd3: w_q <= rd_cur;
							3'd4: n_q <= rd_cur;
							default: ;
						endcase
						if (ph_q == 3'd5) begin
							s_q <= rd_cur;
							ea_q <= addr(r_q, c_q - DMW'(1));
							ph_q <= '0;
							if (c_q == cols - DMW'(1)) begin
								c_q <= DMW'(1);
								r_q <= r_q + DMW'(1);
								if (r_q + DMW'(1) == rows - DMW'(1)) edge_q <= 1'b1;
							end
						end else begin
							ph_q <= ph_q + 3'd1;
							if (ph_q == 3'd4) c_q <= c_q + DMW'(1);
						end
					end else if (pv_q == '0) begin
						r_q <= '0;
						c_q <= '0;
						ph_q <= '0;
						edge_q <= 1'b0;
					end
				end
				hds_pkg::ST_EDGE: begin
					if (ph_q == 3'd0) ea_q <= addr(r_q, c_q);
					if (ph_q == 3'd2) begin
						ph_q <= '0;
						if (c_q != cols - DMW'(1)) begin
							c_q <= c_q + DMW'(1);
						end else if (r_q != rows - DMW'(1)) begin
							c_q <= '0;
							r_q <= r_q + DMW'(1);
						end else begin
							r_q <= DMW'(1);
							c_q <= DMW'(1);
							steps_q <= steps_q - 16'd1;
							sel_q <= ~sel_q;
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				hds_pkg::ST_DONE: begin
					is_read <= (act_q == hds_pkg::ACT_READ);
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == hds_pkg::ST_DONE) begin
			if (act_q == hds_pkg::ACT_READ) begin
				result_value <= (DMW'(rr_q) < rows && DMW'(cc_q) < cols) ? rd_sat : 32'sd0;
				saturated    <= 1'b0;
			end else begin
				result_value <= 32'sd0;
				saturated    <= sat_q;
			end
		end
	end

endmodule

### sv/heat_diffusion_stencil_2d.sv
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_2d
// explicit five-point heat diffusion engine on ping-pong Q16.16 grids
// ----------------------------------------------------------------------------
// Requests enter on start while busy is low and queue two deep ahead of the
// grid engine. A write goes straight into the current grid, and a fill writes
// every cell in use in turn. An advance, per step, reads the five points of
// each interior cell through the single read port of the current grid, passes
// them through the arithmetic pipe and then copies the edge cells. Each
// read or advance gives one result on done for one cycle; it cannot be held.
`include "heat_diffusion_stencil_2d_macros.svh"
module heat_diffusion_stencil_2d #(
	parameter int MAX_DIM    = hds_pkg::MAX_DIM_DEF,
	parameter int VALUE_BITS = hds_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [3:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          action,
	input  logic [hds_pkg::IDX_BITS-1:0]        row,
	input  logic [hds_pkg::IDX_BITS-1:0]        col,
	input  logic signed [31:0]                  cell_value,
	input  logic [hds_pkg::STEP_BITS-1:0]       step_count,
	output logic                                done,
	output logic signed [31:0]                  result_value,
	output logic                                is_read,
	output logic                                saturated
);

	logic [hds_pkg::DIM_BITS-1:0]  rows_q, cols_q;
	logic [hds_pkg::COEF_BITS-1:0] cx_q, cy_q;
	hds_pkg::req_t req, q_req;
	logic q_valid, q_pop;
	hds_pkg::reg_idx_t widx;

	assign pready = 1'b1;
	assign widx   = hds_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 8'd100;
			cols_q <= 8'd100;
			cx_q   <= 24'd41943;
			cy_q   <= 24'd41943;
		end else if (psel && penable && pwrite) begin
			case (widx)
				hds_pkg::REG_ROWS:   rows_q <= pwdata[7:0];
				hds_pkg::REG_COLS:   cols_q <= pwdata[7:0];
				hds_pkg::REG_COEF_X: cx_q   <= pwdata[23:0];
				hds_pkg::REG_COEF_Y: cy_q   <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			hds_pkg::REG_ROWS:   prdata = {24'd0, rows_q};
			hds_pkg::REG_COLS:   prdata = {24'd0, cols_q};
			hds_pkg::REG_COEF_X: prdata = {8'd0, cx_q};
			hds_pkg::REG_COEF_Y: prdata = {8'd0, cy_q};
			default:             prdata = '0;
		endcase
	end

	always_comb begin
		req.action     = hds_pkg::action_t'(action);
		req.row        = row;
		req.col        = col;
		req.cell_value = cell_value;
		req.step_count = step_count;
	end

	hds_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
	);

	hds_back #(.MAX_DIM(MAX_DIM), .VALUE_BITS(VALUE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_req(q_req),
		.q_pop(q_pop), .grid_rows(rows_q), .grid_cols(cols_q), .coef_x(cx_q),
		.coef_y(cy_q), .done(done), .result_value(result_value),
		.is_read(is_read), .saturated(saturated)
	);

	`HDS_ASSERT_IMPL(a_pop_valid, clk, arst_n, q_pop, q_valid, "pop from empty queue")
	`HDS_ASSERT_IMPL(a_read_nosat, clk, arst_n, done && is_read, !saturated, "read flagged sat")
	`HDS_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "done held two cycles")

endmodule

### sim/hds_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hds_checker
// watches the register port and the request and result channels of the heat
// diffusion stencil, keeps its own copy of both grids and the registers,
// predicts each read and advance result and compares it field by field
// ----------------------------------------------------------------------------
module hds_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         action,
	input  logic [6:0]         row,
	input  logic [6:0]         col,
	input  logic signed [31:0] cell_value,
	input  logic [15:0]        step_count,
	input  logic               done,
	input  logic signed [31:0] result_value,
	input  logic               is_read,
	input  logic               saturated,
	output int                 fail_count,
	output int                 pending
);
	import hds_pkg::*;

	localparam int DIM = MAX_DIM_DEF;
	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;

	typedef struct {
		logic signed [31:0] value;
		logic               is_read;
		logic               sat;
	} cell_result_t;

	cell_result_t result_q[$];
	longint       temp_grid[2][DIM*DIM];
	bit           cur_sel;
	bit           sat_any;
	logic [7:0]   rows_reg, cols_reg;
	logic [23:0]  cx_reg, cy_reg;

	assign pending = result_q.size();

	function automatic int clamp_dim(logic [7:0] d);
		if (d < 3) return 3;
		if (d > DIM) return DIM;
		return int'(d);
	endfunction

	function automatic longint clip(longint v);
		if (v > VMAX) begin
			sat_any = 1'b1;
			return VMAX;
		end
		if (v < VMIN) begin
			sat_any = 1'b1;
			return VMIN;
		end
		return v;
	endfunction

	task automatic diffuse_step();
		int nr, nc, i, j, p, cu, nx;
		longint u, lx, ly, cxh, cxl, cyh, cyl, hi, lo, d;
		nr = clamp_dim(rows_reg);
		nc = clamp_dim(cols_reg);
		cu = cur_sel;
		nx = !cur_sel;
		cxh = cx_reg[23:12];
		cxl = cx_reg[11:0];
		cyh = cy_reg[23:12];
		cyl = cy_reg[11:0];
		for (i = 1; i + 1 < nr; i++)
			for (j = 1; j + 1 < nc; j++) begin
				p = i * DIM + j;
				u = temp_grid[cu][p];
				lx = temp_grid[cu][p+DIM] - 2 * u + temp_grid[cu][p-DIM];
				ly = temp_grid[cu][p-1] - 2 * u + temp_grid[cu][p+1];
				hi = cxh * lx + cyh * ly;
				lo = cxl * lx + cyl * ly + 64'sd8388608;
				d = (hi + (lo >>> 12)) >>> 12;
				temp_grid[nx][p] = clip(u + d);
			end
		for (i = 0; i < nr; i++) begin
			temp_grid[nx][i*DIM] = temp_grid[nx][i*DIM+1];
			temp_grid[nx][i*DIM+nc-1] = temp_grid[nx][i*DIM+nc-2];
		end
		for (j = 0; j < nc; j++) begin
			temp_grid[nx][j] = temp_grid[nx][DIM+j];
			temp_grid[nx][(nr-1)*DIM+j] = temp_grid[nx][(nr-2)*DIM+j];
		end
		cur_sel = !cur_sel;
	endtask

	task automatic predict_request();
		int nr, nc, i, j;
		longint v;
		cell_result_t res;
		nr = clamp_dim(rows_reg);
		nc = clamp_dim(cols_reg);
		v = cell_value;
		case (action_t'(action))
			ACT_FILL: begin
				for (i = 0; i < nr; i++)
					for (j = 0; j < nc; j++)
						temp_grid[cur_sel][i*DIM+j] = v;
			end
			ACT_WRITE: begin
				if (row < nr && col < nc)
					temp_grid[cur_sel][row*DIM+col] = v;
			end
			ACT_ADVANCE: begin
				sat_any = 1'b0;
				for (i = 0; i < step_count; i++)
					diffuse_step();
				res.value = '0;
				res.is_read = 1'b0;
				res.sat = sat_any;
				result_q.push_back(res);
			end
			default: begin
				res.value = '0;
				if (row < nr && col < nc)
					res.value = 32'(temp_grid[cur_sel][row*DIM+col]);
				res.is_read = 1'b1;
				res.sat = 1'b0;
				result_q.push_back(res);
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		cell_result_t want;
		if (!arst_n) begin
			result_q.delete();
			cur_sel = 1'b0;
			sat_any = 1'b0;
			rows_reg = 8'd100;
			cols_reg = 8'd100;
			cx_reg = 24'd41943;
			cy_reg = 24'd41943;
			fail_count <= 0;
		end else begin
			if (done) begin
				if (result_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result value=%0d is_read=%0b sat=%0b",
							result_value, is_read, saturated);
				end else begin
					want = result_q.pop_front();
					if (result_value !== want.value || is_read !== want.is_read ||
							saturated !== want.sat) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch exp value=%0d is_read=%0b sat=%0b act value=%0d is_read=%0b sat=%0b",
								want.value, want.is_read, want.sat,
								result_value, is_read, saturated);
					end
				end
			end
			if (psel && penable && pwrite && pready)
				case (reg_idx_t'(paddr[3:2]))
					REG_ROWS:   rows_reg = pwdata[7:0];
					REG_COLS:   cols_reg = pwdata[7:0];
					REG_COEF_X: cx_reg = pwdata[23:0];
					default:    cy_reg = pwdata[23:0];
				endcase
			if (start && !busy)
				predict_request();
		end
	end
endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the heat diffusion stencil: directed requests at
// the grid and coefficient extremes, then random phases on small grids with
// random gaps between requests; checking is done by hds_checker
// ----------------------------------------------------------------------------
module tb_top;
	import hds_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel, penable, pwrite, pready;
	logic [3:0]         paddr;
	logic [31:0]        pwdata, prdata;
	logic               start, busy, done, is_read, saturated;
	logic [1:0]         action;
	logic [6:0]         row, col;
	logic signed [31:0] cell_value, result_value;
	logic [15:0]        step_count;
	int                 fail_count, pending;

	always #6 clk = ~clk;

	heat_diffusion_stencil_2d i_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .action(action), .row(row), .col(col),
		.cell_value(cell_value), .step_count(step_count), .done(done),
		.result_value(result_value), .is_read(is_read), .saturated(saturated)
	);

	hds_checker i_checker (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .pready(pready), .start(start), .busy(busy),
		.action(action), .row(row), .col(col), .cell_value(cell_value),
		.step_count(step_count), .done(done), .result_value(result_value),
		.is_read(is_read), .saturated(saturated), .fail_count(fail_count),
		.pending(pending)
	);

	task automatic reg_write(reg_idx_t idx, logic [31:0] data);
		bit ok;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			ok = pready;
			@(posedge clk);
		end while (!ok);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// hold the request until an edge with busy low takes it
	task automatic send(action_t act, int r, int c, logic [31:0] v, logic [15:0] n);
		bit ok;
		start <= 1'b1;
		action <= act;
		row <= r[6:0];
		col <= c[6:0];
		cell_value <= v;
		step_count <= n;
		do begin
			@(negedge clk);
			ok = !busy;
			@(posedge clk);
		end while (!ok);
	endtask

	task automatic gap();
		int pick, len;
		pick = $urandom_range(99);
		len = pick < 65 ? 0 : (pick < 93 ? $urandom_range(3, 1) : $urandom_range(40, 10));
		if (len > 0) begin
			start <= 1'b0;
			repeat (len) @(posedge clk);
		end
	endtask

	// a read closes the phase, so its result means the engine is idle
	task automatic settle();
		send(ACT_READ, 0, 0, $urandom, 16'($urandom));
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic random_phase();
		int nr, nc, k, pick, r, c;
		nr = $urandom_range(10, 3);
		nc = $urandom_range(10, 3);
		if ($urandom_range(3) == 0) nr = $urandom_range(2);
		reg_write(REG_ROWS, {24'($urandom), 8'(nr)});
		reg_write(REG_COLS, {24'($urandom), 8'(nc)});
		reg_write(REG_COEF_X, $urandom_range(3) == 0 ? $urandom : $urandom_range(8388608));
		reg_write(REG_COEF_Y, $urandom_range(3) == 0 ? $urandom : $urandom_range(8388608));
		if (nr < 3) nr = 3;
		send(ACT_FILL, $urandom, $urandom, $urandom, 16'($urandom));
		for (k = 0; k < 16; k++) begin
			gap();
			pick = $urandom_range(99);
			r = $urandom_range(4) == 0 ? $urandom_range(127) : $urandom_range(nr - 1);
			c = $urandom_range(4) == 0 ? $urandom_range(127) : $urandom_range(nc - 1);
			if (pick < 35)
				send(ACT_WRITE, r, c, $urandom, 16'($urandom));
			else if (pick < 65)
				send(ACT_READ, r, c, $urandom, 16'($urandom));
			else if (pick < 95)
				send(ACT_ADVANCE, $urandom, $urandom, $urandom, 16'($urandom_range(12)));
			else
				send(ACT_FILL, $urandom, $urandom, $urandom, 16'($urandom));
		end
		settle();
	endtask

	initial begin
		#(12.0 * 20000000);
		$display("FAIL");
		$finish;
	end

	initial begin
		int p;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		start <= 1'b0;
		action <= ACT_FILL;
		row <= '0;
		col <= '0;
		cell_value <= '0;
		step_count <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full grid, so that both grids are written everywhere
		reg_write(REG_ROWS, 32'd128);
		reg_write(REG_COLS, 32'd255);
		send(ACT_FILL, 0, 0, 32'h0001_0000, 16'hffff);
		send(ACT_WRITE, 0, 0, 32'h7fff_ffff, 16'h0000);
		send(ACT_WRITE, 127, 127, 32'h8000_0000, 16'h0000);
		send(ACT_WRITE, 64, 64, 32'h0005_0000, 16'h0000);
		send(ACT_READ, 127, 127, 32'hffff_ffff, 16'hffff);
		send(ACT_READ, 0, 0, 32'h0, 16'h0);
		send(ACT_ADVANCE, 0, 0, 32'h0, 16'd1);
		send(ACT_READ, 64, 64, 32'h0, 16'h0);
		settle();

		// smallest grid, large coefficients, saturation
		reg_write(REG_ROWS, 32'd0);
		reg_write(REG_COLS, 32'd3);
		reg_write(REG_COEF_X, 32'h00ff_ffff);
		reg_write(REG_COEF_Y, 32'h0080_0000);
		send(ACT_FILL, 0, 0, 32'h7fff_ffff, 16'h0);
		send(ACT_WRITE, 3, 1, 32'h0, 16'h0);
		send(ACT_WRITE, 1, 1, 32'h8000_0000, 16'h0);
		send(ACT_READ, 1, 5, 32'h0, 16'h0);
		send(ACT_ADVANCE, 0, 0, 32'h0, 16'd0);
		send(ACT_ADVANCE, 0, 0, 32'h0, 16'd2);
		send(ACT_READ, 1, 1, 32'h0, 16'h0);
		settle();
		reg_write(REG_COEF_X, 32'h0);
		reg_write(REG_COEF_Y, 32'h0);
		send(ACT_ADVANCE, 0, 0, 32'h0, 16'd3);
		send(ACT_READ, 2, 2, 32'h0, 16'h0);
		settle();

		for (p = 0; p < 5; p++)
			random_phase();

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

### files.f
+incdir+sv
sv/hds_pkg.sv
sv/hds_front.sv
sv/hds_back.sv
sv/heat_diffusion_stencil_2d.sv
sim/hds_checker.sv
sim/tb_top.sv
